>>> sv/rvgc_pkg.sv
// ----------------------------------------------------------------------------
// rvgc_pkg
// Shared types and constants of the radial vignetting gain corrector.
// ----------------------------------------------------------------------------
package rvgc_pkg;

  localparam int POS_W     = 13;
  localparam int CTR_W     = 12;
  localparam int SCALE_W   = 17;
  localparam int LEN_W     = 7;
  localparam int IDX_W     = 6;
  localparam int ENTRY_W   = 16;
  localparam int CHAN_W    = 8;
  localparam int FRAC_W    = 8;
  localparam int GAIN_W    = 24;
  localparam int SHIFT_Q   = 16;
  localparam int DIV_BITS  = 8;
  localparam int NUM_CHAN  = 3;
  localparam int DIV_SHIFT = 22;

  localparam int DEF_MAX_PROFILE = 64;
  localparam int DEF_COORD_BITS  = 13;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 17'd65536;
  localparam logic [LEN_W-1:0]   LEN_RESET   = 7'd64;
  localparam logic [CTR_W-1:0]   CTR_RESET   = 12'd0;
  localparam int                 HALF_Q8     = 128;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_RADIUS_SCALE,
    REG_PROFILE_LENGTH
  } reg_idx_t;

  typedef struct packed {
    logic               func;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [IDX_W-1:0]   entry_index;
    logic [ENTRY_W-1:0] entry_value;
    logic [CHAN_W-1:0]  chan_a;
    logic [CHAN_W-1:0]  chan_b;
    logic [CHAN_W-1:0]  chan_c;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_a;
    logic [CHAN_W-1:0] out_b;
    logic [CHAN_W-1:0] out_c;
  } out_item_t;

  typedef struct packed {
    logic                              valid;
    logic                              func;
    logic [IDX_W-1:0]                  entry_index;
    logic [ENTRY_W-1:0]                entry_value;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]   chan;
  } side_t;

endpackage

>>> sv/rvgc_stream_if.sv
// ----------------------------------------------------------------------------
// rvgc_stream_if
// Valid/ready stream channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface rvgc_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/radial_vignetting_gain_correct.sv
// ----------------------------------------------------------------------------
// radial_vignetting_gain_correct
// Radial vignetting correction of an RGB pixel stream with a loadable profile.
// ----------------------------------------------------------------------------
// The feed channel takes one item per cycle unless the result channel stalls.
// An item with func low writes one entry of the gain profile and gives no
// result. An item with func high is a pixel; it gives one result on the
// result channel with the three channels divided by the interpolated profile
// gain, saturated at 255. Throughput is one item per cycle while the result
// receiver does not stall; the square root and the divider are fully
// pipelined. Profile writes take effect in stream order, so a pixel sees
// every write accepted before it. When the result receiver stalls, the whole
// pipeline holds and feed.ready drops; nothing is lost or repeated.
// Reset clears all valid bits and sets the registers to their defaults; the
// profile itself holds no defined value until written.
// The APB port writes and reads center_x, center_y, radius_scale and
// profile_length at byte addresses 0, 4, 8 and 12; pready is always high.
// ----------------------------------------------------------------------------
module radial_vignetting_gain_correct
  import rvgc_pkg::*;
#(
  parameter int MAX_PROFILE = DEF_MAX_PROFILE,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  logic         clk,
  input  logic         rst,
  rvgc_stream_if.sink   feed,
  rvgc_stream_if.source result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int CU  = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
  localparam int DW  = ((CU > CTR_W) ? CU : CTR_W) + 1;
  localparam int SQW = 2 * DW - 2;
  localparam int D2W = SQW + 1;
  localparam int RW  = DW + FRAC_W;
  localparam int NRW = RW - 6;
  localparam int PW  = RW + 1 + SCALE_W;

  logic [CTR_W-1:0]   center_x;
  logic [CTR_W-1:0]   center_y;
  logic [SCALE_W-1:0] radius_scale;
  logic [LEN_W-1:0]   profile_length;
  reg_idx_t           ridx;
  logic               en;

  side_t                 side_c;
  side_t                 side1, side2, side3, side_sq, side_sc, side_pf;
  logic signed [DW-1:0]  dx_c, dy_c, dx1, dy1;
  logic signed [2*DW-1:0] px, py;
  logic [SQW-1:0]        sqx2, sqy2;
  logic [D2W-1:0]        d2_3;
  logic [RW-1:0]         root;
  logic [RW:0]           rq;
  logic [PW-1:0]         prod;
  logic [NRW-1:0]        nr;
  logic [FRAC_W-1:0]     dr;
  logic [GAIN_W-1:0]     gain;
  logic                  dv_valid, dv_func;
  out_item_t             dv_item;

  // Configuration port.
  assign ridx   = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= CTR_RESET;
      center_y       <= CTR_RESET;
      radius_scale   <= SCALE_RESET;
      profile_length <= LEN_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_CENTER_X:       center_x       <= pwdata[CTR_W-1:0];
        REG_CENTER_Y:       center_y       <= pwdata[CTR_W-1:0];
        REG_RADIUS_SCALE:   radius_scale   <= pwdata[SCALE_W-1:0];
        REG_PROFILE_LENGTH: profile_length <= pwdata[LEN_W-1:0];
        default:            center_x       <= center_x;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_CENTER_X:       prdata = 32'(center_x);
      REG_CENTER_Y:       prdata = 32'(center_y);
      REG_RADIUS_SCALE:   prdata = 32'(radius_scale);
      REG_PROFILE_LENGTH: prdata = 32'(profile_length);
      default:            prdata = '0;
    endcase
  end

  // The pipeline advances as a whole unless a result waits.
  assign en          = !result.valid || result.ready;
  assign feed.ready  = en;

  assign side_c.valid       = feed.valid;
  assign side_c.func        = feed.data.func;
  assign side_c.entry_index = feed.data.entry_index;
  assign side_c.entry_value = feed.data.entry_value;
  assign side_c.chan        = {feed.data.chan_c, feed.data.chan_b, feed.data.chan_a};

  assign dx_c = $signed(DW'(feed.data.pos_x[CU-1:0])) - $signed(DW'(center_x));
  assign dy_c = $signed(DW'(feed.data.pos_y[CU-1:0])) - $signed(DW'(center_y));
  assign px   = dx1 * dx1;
  assign py   = dy1 * dy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      side1.valid   <= 1'b0;
      side2.valid   <= 1'b0;
      side3.valid   <= 1'b0;
      side_sc.valid <= 1'b0;
    end else if (en) begin
      side1.valid   <= side_c.valid;
      side2.valid   <= side1.valid;
      side3.valid   <= side2.valid;
      side_sc.valid <= side_sq.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1.func        <= side_c.func;
      side1.entry_index <= side_c.entry_index;
      side1.entry_value <= side_c.entry_value;
      side1.chan        <= side_c.chan;
      dx1               <= dx_c;
      dy1               <= dy_c;
      side2.func        <= side1.func;
      side2.entry_index <= side1.entry_index;
      side2.entry_value <= side1.entry_value;
      side2.chan        <= side1.chan;
      sqx2              <= px[SQW-1:0];
      sqy2              <= py[SQW-1:0];
      side3.func        <= side2.func;
      side3.entry_index <= side2.entry_index;
      side3.entry_value <= side2.entry_value;
      side3.chan        <= side2.chan;
      d2_3              <= D2W'(sqx2) + D2W'(sqy2);
    end
  end

  rvgc_sqrt #(
    .RW (RW)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .side_in  (side3),
    .rad      ({1'b0, d2_3, 16'd0}),
    .side_out (side_sq),
    .root     (root)
  );

  assign rq   = (RW+1)'(root) + (RW+1)'(HALF_Q8);
  assign prod = PW'(rq) * PW'(radius_scale);

  always_ff @(posedge clk) begin
    if (en) begin
      side_sc.func        <= side_sq.func;
      side_sc.entry_index <= side_sq.entry_index;
      side_sc.entry_value <= side_sq.entry_value;
      side_sc.chan        <= side_sq.chan;
      nr                  <= prod[PW-1:SHIFT_Q+FRAC_W];
      dr                  <= prod[SHIFT_Q+FRAC_W-1:SHIFT_Q];
    end
  end

  rvgc_profile #(
    .MAX_PROFILE (MAX_PROFILE),
    .NRW         (NRW)
  ) u_profile (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .side_in        (side_sc),
    .nr             (nr),
    .dr             (dr),
    .profile_length (profile_length),
    .side_out       (side_pf),
    .gain           (gain)
  );

  rvgc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .side_in (side_pf),
    .gain    (gain),
    .valid   (dv_valid),
    .func    (dv_func),
    .item    (dv_item)
  );

  assign result.valid = dv_valid && (dv_func == FUNC_PIXEL);
  assign result.data  = dv_item;

  a_stall_freezes_front: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(side1.valid) && $stable(side3.valid) && $stable(side_sc.valid))
    else $error("pipeline moved while the result was stalled");

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !result.valid && !side_sc.valid)
    else $error("result valid right after reset");

  a_write_gives_no_result: assert property (@(posedge clk) disable iff (rst)
    dv_valid && (dv_func == FUNC_WRITE) |-> !result.valid)
    else $error("profile write item produced a result");

endmodule

>>> sv/rvgc_sqrt.sv
// ----------------------------------------------------------------------------
// rvgc_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module rvgc_sqrt
  import rvgc_pkg::*;
#(
  parameter int RW = 22
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  side_t           side_in,
  input  logic [2*RW-1:0] rad,
  output side_t           side_out,
  output logic [RW-1:0]   root
);

  side_t           side_q [RW];
  logic [RW+1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] rad_q  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    side_t           s_in;
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic [2*RW-1:0] rad_in;
    logic [RW+1:0]   r2;
    logic [RW+1:0]   trial;

    if (i == 0) begin : g_first
      assign s_in    = side_in;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign s_in    = side_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
    end

    assign r2    = {rem_in[RW-1:0], rad_in[2*RW-1 -: 2]};
    assign trial = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        side_q[i].valid <= 1'b0;
      end else if (en) begin
        side_q[i].valid <= s_in.valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[i].func        <= s_in.func;
        side_q[i].entry_index <= s_in.entry_index;
        side_q[i].entry_value <= s_in.entry_value;
        side_q[i].chan        <= s_in.chan;
        rad_q[i]              <= {rad_in[2*RW-3:0], 2'b00};
        if (r2 >= trial) begin
          rem_q[i]  <= r2 - trial;
          root_q[i] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_q[i]  <= r2;
          root_q[i] <= {root_in[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign side_out = side_q[RW-1];
  assign root     = root_q[RW-1];

endmodule

>>> sv/rvgc_profile.sv
// ----------------------------------------------------------------------------
// rvgc_profile
// Gain profile memory with entry writes and two-point interpolated lookup.
// ----------------------------------------------------------------------------
module rvgc_profile
  import rvgc_pkg::*;
#(
  parameter int MAX_PROFILE = DEF_MAX_PROFILE,
  parameter int NRW         = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  side_t             side_in,
  input  logic [NRW-1:0]    nr,
  input  logic [FRAC_W-1:0] dr,
  input  logic [LEN_W-1:0]  profile_length,
  output side_t             side_out,
  output logic [GAIN_W-1:0] gain
);

  localparam int AW = (MAX_PROFILE > 1) ? $clog2(MAX_PROFILE) : 1;

  logic [ENTRY_W-1:0] mem [MAX_PROFILE];

  logic [NRW-1:0]    len_e;
  logic [AW-1:0]     lo_addr;
  logic [AW-1:0]     hi_addr;
  logic [FRAC_W-1:0] wt;
  logic [8:0]        widx;
  logic              we;

  side_t              side1;
  logic [ENTRY_W-1:0] lo_d;
  logic [ENTRY_W-1:0] hi_d;
  logic [FRAC_W-1:0]  wt1;
  logic [ENTRY_W+FRAC_W:0] g_sum;

  always_comb begin
    priority if (profile_length == '0) begin
      len_e = NRW'(1);
    end else if (NRW'(profile_length) > NRW'(MAX_PROFILE)) begin
      len_e = NRW'(MAX_PROFILE);
    end else begin
      len_e = NRW'(profile_length);
    end
  end

  always_comb begin
    priority if (nr == '0) begin
      lo_addr = '0;
      hi_addr = '0;
      wt      = '0;
    end else if (nr < len_e) begin
      lo_addr = AW'(nr - NRW'(1));
      hi_addr = AW'(nr);
      wt      = dr;
    end else begin
      lo_addr = AW'(len_e - NRW'(1));
      hi_addr = AW'(len_e - NRW'(1));
      wt      = '0;
    end
  end

  assign widx = 9'(side_in.entry_index);
  assign we   = side_in.valid && (side_in.func == FUNC_WRITE) && (widx < 9'(MAX_PROFILE));

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[widx[AW-1:0]] <= side_in.entry_value;
      end
      lo_d <= mem[lo_addr];
      hi_d <= mem[hi_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side1.valid    <= 1'b0;
      side_out.valid <= 1'b0;
    end else if (en) begin
      side1.valid    <= side_in.valid;
      side_out.valid <= side1.valid;
    end
  end

  assign g_sum = (ENTRY_W+FRAC_W+1)'(lo_d) * (ENTRY_W+FRAC_W+1)'(9'd256 - {1'b0, wt1})
               + (ENTRY_W+FRAC_W+1)'(hi_d) * (ENTRY_W+FRAC_W+1)'(wt1);

  always_ff @(posedge clk) begin
    if (en) begin
      side1.func           <= side_in.func;
      side1.entry_index    <= side_in.entry_index;
      side1.entry_value    <= side_in.entry_value;
      side1.chan           <= side_in.chan;
      wt1                  <= wt;
      side_out.func        <= side1.func;
      side_out.entry_index <= side1.entry_index;
      side_out.entry_value <= side1.entry_value;
      side_out.chan        <= side1.chan;
      gain                 <= g_sum[GAIN_W-1:0];
    end
  end

endmodule

>>> sv/rvgc_div.sv
// ----------------------------------------------------------------------------
// rvgc_div
// Pipelined restoring divider, one quotient bit per stage for three channels.
// ----------------------------------------------------------------------------
module rvgc_div
  import rvgc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  side_t             side_in,
  input  logic [GAIN_W-1:0] gain,
  output logic              valid,
  output logic              func,
  output out_item_t         item
);

  localparam int REM_W = CHAN_W + DIV_SHIFT;

  logic                    v_q    [DIV_BITS];
  logic                    f_q    [DIV_BITS];
  logic [GAIN_W-1:0]       g_q    [DIV_BITS];
  logic [NUM_CHAN-1:0]     sat_q  [DIV_BITS];
  logic [REM_W-1:0]        rem_q  [DIV_BITS][NUM_CHAN];
  logic [CHAN_W-1:0]       quo_q  [DIV_BITS][NUM_CHAN];

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_stage
    logic                v_in;
    logic                f_in;
    logic [GAIN_W-1:0]   g_in;
    logic [NUM_CHAN-1:0] sat_in;
    logic [REM_W-1:0]    rem_in [NUM_CHAN];
    logic [CHAN_W-1:0]   quo_in [NUM_CHAN];
    logic [31:0]         gs;

    if (i == 0) begin : g_first
      assign v_in = side_in.valid;
      assign f_in = side_in.func;
      assign g_in = gain;
      for (genvar l = 0; l < NUM_CHAN; l++) begin : g_lane
        assign sat_in[l] = GAIN_W'({side_in.chan[l], 14'd0}) >= gain;
        assign rem_in[l] = {side_in.chan[l], 22'd0};
        assign quo_in[l] = '0;
      end
    end else begin : g_next
      assign v_in   = v_q[i-1];
      assign f_in   = f_q[i-1];
      assign g_in   = g_q[i-1];
      assign sat_in = sat_q[i-1];
      for (genvar l = 0; l < NUM_CHAN; l++) begin : g_lane
        assign rem_in[l] = rem_q[i-1][l];
        assign quo_in[l] = quo_q[i-1][l];
      end
    end

    assign gs = 32'(g_in) << (DIV_BITS - 1 - i);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= v_in;
      end
    end

    for (genvar l = 0; l < NUM_CHAN; l++) begin : g_calc
      logic [31:0] diff;
      logic        take;
      assign diff = 32'(rem_in[l]) - gs;
      assign take = 32'(rem_in[l]) >= gs;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i][l] <= take ? diff[REM_W-1:0] : rem_in[l];
          quo_q[i][l] <= {quo_in[l][CHAN_W-2:0], take};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        f_q[i]   <= f_in;
        g_q[i]   <= g_in;
        sat_q[i] <= sat_in;
      end
    end
  end

  assign valid      = v_q[DIV_BITS-1];
  assign func       = f_q[DIV_BITS-1];
  assign item.out_a = sat_q[DIV_BITS-1][0] ? 8'hFF : quo_q[DIV_BITS-1][0];
  assign item.out_b = sat_q[DIV_BITS-1][1] ? 8'hFF : quo_q[DIV_BITS-1][1];
  assign item.out_c = sat_q[DIV_BITS-1][2] ? 8'hFF : quo_q[DIV_BITS-1][2];

endmodule

>>> dv/tb_radial_vignetting_gain_correct.sv
// ----------------------------------------------------------------------------
// tb_radial_vignetting_gain_correct
// Self-checking testbench of the radial vignetting gain corrector.
// ----------------------------------------------------------------------------
// Profile writes and pixels are fed through the stream channel with random
// gaps, results are drained with random stalls and compared field by field
// against a predictor kept in the testbench. The registers are set over APB
// between phases, including their extremes.
// ----------------------------------------------------------------------------
module tb_radial_vignetting_gain_correct;
  import rvgc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rvgc_stream_if #(.item_t(in_item_t)) feed ();
  rvgc_stream_if #(.item_t(out_item_t)) result ();

  radial_vignetting_gain_correct DUT (
    .clk(clk), .rst(rst), .feed(feed), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  localparam int LIMIT = 400000;

  in_item_t pending_items[$];
  out_item_t expected_pixels[$];
  logic [ENTRY_W-1:0] gain_table[DEF_MAX_PROFILE];
  bit written[DEF_MAX_PROFILE];
  logic [CTR_W-1:0] ctr_x, ctr_y;
  logic [SCALE_W-1:0] scale;
  logic [LEN_W-1:0] prof_len;
  int mismatches = 0;
  int pixels_checked = 0;
  int cycles = 0;
  bit quiet = 0;
  bit hold_long = 0;
  bit feed_taken = 0;
  int feed_gap = 0;
  int drain_gap = 0;
  int hold_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    feed.valid = 1'b0;
    feed.data = '0;
    result.ready = 1'b0;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [7:0] divide_chan(input logic [7:0] c, input logic [63:0] g);
    logic [63:0] q;
    if (g == 0) return 8'd255;
    q = ({56'd0, c} << DIV_SHIFT) / g;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // Returns 1 and the corrected pixel for a pixel item; applies a profile write otherwise.
  function automatic bit correct_pixel(input in_item_t it, output out_item_t o);
    longint dx, dy;
    logic [63:0] d2, rq, rs, nr, dr, g, len;
    if (it.func == FUNC_WRITE) begin
      gain_table[it.entry_index] = it.entry_value;
      return 0;
    end
    len = prof_len;
    if (len == 0) len = 1;
    if (len > DEF_MAX_PROFILE) len = DEF_MAX_PROFILE;
    dx = longint'(it.pos_x) - longint'(ctr_x);
    dy = longint'(it.pos_y) - longint'(ctr_y);
    d2 = dx * dx + dy * dy;
    rq = isqrt(d2 << 16) + HALF_Q8;
    rs = (rq * scale) >> 16;
    nr = rs >> 8;
    dr = rs & 255;
    if (nr == 0) g = {48'd0, gain_table[0]} << 8;
    else if (nr < len) g = gain_table[nr-1] * (256 - dr) + gain_table[nr] * dr;
    else g = {48'd0, gain_table[len-1]} << 8;
    o.out_a = divide_chan(it.chan_a, g);
    o.out_b = divide_chan(it.chan_b, g);
    o.out_c = divide_chan(it.chan_c, g);
    return 1;
  endfunction

  always @(negedge clk) begin
    if (!rst) begin
      if (feed.valid && !feed_taken) begin
        feed.valid <= 1'b1;
      end else if (feed_gap > 0) begin
        feed_gap <= feed_gap - 1;
        feed.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        feed_gap <= $urandom_range(0, 12);
        feed.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        feed.valid <= 1'b1;
        feed.data <= pending_items[0];
      end else begin
        feed.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_long) begin
      hold_count <= hold_count + 1;
      result.ready <= 1'b0;
    end else if (drain_gap > 0) begin
      drain_gap <= drain_gap - 1;
      result.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      drain_gap <= $urandom_range(0, 12);
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_item_t e, feed_out;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    feed_taken <= !rst && feed.valid && feed.ready;
    if (!rst && feed.valid && feed.ready) begin
      void'(pending_items.pop_front());
      if (correct_pixel(feed.data, feed_out)) expected_pixels.push_back(feed_out);
    end
    if (!rst && result.valid && result.ready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result.data);
      end else begin
        e = expected_pixels.pop_front();
        pixels_checked++;
        if (e !== result.data) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected a=%0d b=%0d c=%0d, got a=%0d b=%0d c=%0d",
                     e.out_a, e.out_b, e.out_c,
                     result.data.out_a, result.data.out_b, result.data.out_c);
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || expected_pixels.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t r, input logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(r) << 2; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (r)
      REG_CENTER_X: ctr_x = v[CTR_W-1:0];
      REG_CENTER_Y: ctr_y = v[CTR_W-1:0];
      REG_RADIUS_SCALE: scale = v[SCALE_W-1:0];
      default: prof_len = v[LEN_W-1:0];
    endcase
  endtask

  task automatic push_write(input int idx, input logic [15:0] v);
    in_item_t it;
    it = '0;
    it.func = FUNC_WRITE;
    it.entry_index = idx;
    it.entry_value = v;
    it.pos_x = $urandom; it.pos_y = $urandom;
    it.chan_a = $urandom; it.chan_b = $urandom; it.chan_c = $urandom;
    pending_items.push_back(it);
    written[idx] = 1;
  endtask

  task automatic push_pixel(input logic [12:0] x, input logic [12:0] y,
                            input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    in_item_t it;
    it = '0;
    it.func = FUNC_PIXEL;
    it.pos_x = x; it.pos_y = y;
    it.chan_a = a; it.chan_b = b; it.chan_c = c;
    it.entry_index = $urandom; it.entry_value = $urandom;
    pending_items.push_back(it);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        push_write($urandom_range(0, DEF_MAX_PROFILE - 1),
                   ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom));
      end else begin
        push_pixel($urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    ctr_x = CTR_RESET; ctr_y = CTR_RESET; scale = SCALE_RESET; prof_len = LEN_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole profile first so no pixel reads an unwritten entry.
    for (int i = 0; i < DEF_MAX_PROFILE; i++) push_write(i, 16'd16384 + 16'(i * 700));
    push_write(0, 16'hFFFF);
    push_write(1, 16'd0);
    push_pixel(13'd0, 13'd0, 8'd0, 8'd255, 8'd128);
    push_pixel(13'd1, 13'd0, 8'd255, 8'd255, 8'd255);
    push_pixel(13'd8191, 13'd8191, 8'd255, 8'd1, 8'd0);
    push_pixel(13'd3, 13'd4, 8'd200, 8'd100, 8'd50);
    push_pixel(13'd40, 13'd9, 8'd77, 8'd88, 8'd99);
    wait_drained();

    reg_write(REG_CENTER_X, 32'd4095);
    reg_write(REG_CENTER_Y, 32'd4095);
    reg_write(REG_RADIUS_SCALE, 32'd0);
    reg_write(REG_PROFILE_LENGTH, 32'd1);
    push_pixel(13'd0, 13'd8191, 8'd255, 8'd0, 8'd17);
    random_phase(60);
    wait_drained();

    reg_write(REG_CENTER_X, 32'd640);
    reg_write(REG_CENTER_Y, 32'd360);
    reg_write(REG_RADIUS_SCALE, 32'd1);
    reg_write(REG_PROFILE_LENGTH, 32'd64);
    random_phase(60);
    // Long receiver hold while items keep coming, so the pipeline backs up.
    hold_long = 1;
    while (hold_count < 200) @(posedge clk);
    hold_long = 0;
    wait_drained();

    reg_write(REG_RADIUS_SCALE, 32'd120);
    reg_write(REG_PROFILE_LENGTH, 32'd0);
    random_phase(60);
    wait_drained();

    reg_write(REG_CENTER_X, 32'd100);
    reg_write(REG_CENTER_Y, 32'd50);
    reg_write(REG_RADIUS_SCALE, 32'd65535);
    reg_write(REG_PROFILE_LENGTH, 32'd127);
    random_phase(60);
    wait_drained();

    reg_write(REG_CENTER_X, 32'($urandom_range(0, 4095)));
    reg_write(REG_CENTER_Y, 32'($urandom_range(0, 4095)));
    reg_write(REG_RADIUS_SCALE, 32'd131071);
    reg_write(REG_PROFILE_LENGTH, 32'd33);
    random_phase(60);
    wait_drained();

    reg_write(REG_CENTER_X, 32'd0);
    reg_write(REG_CENTER_Y, 32'd0);
    reg_write(REG_RADIUS_SCALE, 32'd65536);
    reg_write(REG_PROFILE_LENGTH, 32'd64);
    random_phase(40);
    wait_drained();
    quiet = 1;
    random_phase(40);
    wait_drained();

    $display("Covered profile writes, %0d checked pixels over seven register settings,",
             pixels_checked);
    $display("random stalls on both sides and one long receiver hold.");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> radial_vignetting_gain_correct.f
sv/rvgc_pkg.sv
sv/rvgc_stream_if.sv
sv/rvgc_sqrt.sv
sv/rvgc_profile.sv
sv/rvgc_div.sv
sv/radial_vignetting_gain_correct.sv
dv/tb_radial_vignetting_gain_correct.sv
